[sv/csc_pkg.sv]
// ----------------------------------------------------------------------------
// Colour space converter package
// Shared widths, conversion mode codes and the pixel type.
// ----------------------------------------------------------------------------
package csc_pkg;

   localparam int CHAN_W              = 8;
   localparam int MODE_W              = 2;
   localparam int COEF_FRAC_BITS_DEF  = 16;

   // conversion modes
   localparam logic [MODE_W-1:0] MODE_RGB_TO_YCC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_YCC_TO_RGB  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RGB_TO_GREY = 2'd2;
   localparam logic [MODE_W-1:0] MODE_YCC_TO_GREY = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] b;
      logic [CHAN_W-1:0] c;
   } pix_type;

endpackage

[sv/csc_req_if.sv]
// ----------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel carrying one three-channel input pixel.
// ----------------------------------------------------------------------------
interface csc_req_if
   import csc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] chan_a;
   logic [CHAN_W-1:0] chan_b;
   logic [CHAN_W-1:0] chan_c;

   modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
   modport sink   (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

[sv/csc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Pixel response channel
// Valid/ready channel carrying one three-channel converted pixel.
// ----------------------------------------------------------------------------
interface csc_rsp_if
   import csc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_a;
   logic [CHAN_W-1:0] out_b;
   logic [CHAN_W-1:0] out_c;

   modport source (output valid, output out_a, output out_b, output out_c, input ready);
   modport sink   (input valid, input out_a, input out_b, input out_c, output ready);
endinterface

[sv/csc_datapath.sv]
// ----------------------------------------------------------------------------
// Colour space converter datapath
// Fixed-point multiply-add, floor and clamp to 0..255 for three conversions; YCbCr to grey copies luma.
// ----------------------------------------------------------------------------
module csc_datapath
   import csc_pkg::*;
#(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic [MODE_W-1:0] mode,
   input  pix_type           in_pix,
   output pix_type           out_pix
);

   localparam int F  = COEF_FRAC_BITS;
   localparam int SW = F + 12;   // every sum stays well inside this

   // coefficients rounded to nearest, ties up
   localparam longint KYR_L  = ((longint'(299)     <<< F) + 500)    / 1000;
   localparam longint KYG_L  = ((longint'(587)     <<< F) + 500)    / 1000;
   localparam longint KYB_L  = ((longint'(114)     <<< F) + 500)    / 1000;
   localparam longint KUR_L  = ((longint'(168736)  <<< F) + 500000) / 1000000;
   localparam longint KUG_L  = ((longint'(331264)  <<< F) + 500000) / 1000000;
   localparam longint KHF_L  = ((longint'(1)       <<< F) + 1)      / 2;
   localparam longint KVG_L  = ((longint'(418688)  <<< F) + 500000) / 1000000;
   localparam longint KVB_L  = ((longint'(81312)   <<< F) + 500000) / 1000000;
   localparam longint KRV_L  = ((longint'(1401999) <<< F) + 500000) / 1000000;
   localparam longint KGU_L  = ((longint'(344136)  <<< F) + 500000) / 1000000;
   localparam longint KGV_L  = ((longint'(714136)  <<< F) + 500000) / 1000000;
   localparam longint KBU_L  = ((longint'(1772)    <<< F) + 500)    / 1000;

   localparam logic signed [SW-1:0] K_YR  = SW'(KYR_L);
   localparam logic signed [SW-1:0] K_YG  = SW'(KYG_L);
   localparam logic signed [SW-1:0] K_YB  = SW'(KYB_L);
   localparam logic signed [SW-1:0] K_UR  = SW'(KUR_L);
   localparam logic signed [SW-1:0] K_UG  = SW'(KUG_L);
   localparam logic signed [SW-1:0] K_HF  = SW'(KHF_L);
   localparam logic signed [SW-1:0] K_VG  = SW'(KVG_L);
   localparam logic signed [SW-1:0] K_VB  = SW'(KVB_L);
   localparam logic signed [SW-1:0] K_RV  = SW'(KRV_L);
   localparam logic signed [SW-1:0] K_GU  = SW'(KGU_L);
   localparam logic signed [SW-1:0] K_GV  = SW'(KGV_L);
   localparam logic signed [SW-1:0] K_BU  = SW'(KBU_L);
   localparam logic signed [SW-1:0] OFF_Q = SW'(longint'(128) <<< F);

   localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

   logic signed [SW-1:0] a_s, b_s, c_s, u_s, v_s, y_s;
   logic signed [SW-1:0] sum_y, sum_cb, sum_cr, sum_r, sum_g, sum_b;
   logic [CHAN_W-1:0]    y_o, cb_o, cr_o, r_o, g_o, b_o;

   // floor by dropping the fraction, then clamp
   function automatic logic [CHAN_W-1:0] floor_sat(input logic signed [SW-1:0] s);
      logic [CHAN_W-1:0] r;
      if (s[SW-1]) begin
         r = '0;
      end else if (|s[SW-2:F+CHAN_W]) begin
         r = CHAN_MAX;
      end else begin
         r = s[F+CHAN_W-1:F];
      end
      return r;
   endfunction

   always_comb begin
      a_s = SW'($signed({1'b0, in_pix.a}));
      b_s = SW'($signed({1'b0, in_pix.b}));
      c_s = SW'($signed({1'b0, in_pix.c}));
      u_s = b_s - SW'(128);
      v_s = c_s - SW'(128);
      y_s = a_s <<< F;

      sum_y  = K_YR * a_s + K_YG * b_s + K_YB * c_s;
      sum_cb = OFF_Q - K_UR * a_s - K_UG * b_s + K_HF * c_s;
      sum_cr = OFF_Q + K_HF * a_s - K_VG * b_s - K_VB * c_s;
      sum_r  = y_s + K_RV * v_s;
      sum_g  = y_s - K_GU * u_s - K_GV * v_s;
      sum_b  = y_s + K_BU * u_s;

      y_o  = floor_sat(sum_y);
      cb_o = floor_sat(sum_cb);
      cr_o = floor_sat(sum_cr);
      r_o  = floor_sat(sum_r);
      g_o  = floor_sat(sum_g);
      b_o  = floor_sat(sum_b);

      case (mode)
         MODE_RGB_TO_YCC: begin
            out_pix.a = y_o;
            out_pix.b = cb_o;
            out_pix.c = cr_o;
         end
         MODE_YCC_TO_RGB: begin
            out_pix.a = r_o;
            out_pix.b = g_o;
            out_pix.c = b_o;
         end
         MODE_RGB_TO_GREY: begin
            out_pix.a = y_o;
            out_pix.b = y_o;
            out_pix.c = y_o;
         end
         default: begin
            out_pix.a = in_pix.a;
            out_pix.b = in_pix.a;
            out_pix.c = in_pix.a;
         end
      endcase
   end

endmodule

[sv/color_space_pixel_converter.sv]
// ----------------------------------------------------------------------------
// Colour space pixel converter
// RGB / full-range BT.601 YCbCr / grey conversion of one pixel per clock when not stalled.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock and returns one converted pixel per clock while
// the sink is ready. An accepted request is held in the pixel register, passes
// a single multiply-add and is registered in the result register, which drives
// rsp_bus; the rate of one pixel per cycle when the output is not stalled is
// set by that single multiply-add pass between the two registers. The
// result register decouples the two sides, so a new request is taken while a
// finished pixel still waits. csr_wr_data selects the mode (0 RGB to YCbCr,
// 1 YCbCr to RGB, 2 RGB to grey, 3 YCbCr to grey) and must only be written
// while no request is in flight.
module color_space_pixel_converter
   import csc_pkg::*;
#(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   csc_req_if.sink           req_bus,
   csc_rsp_if.source         rsp_bus,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              s1_valid_ff, s1_valid_in;
   pix_type           s1_pix_ff, s1_pix_in;
   logic              s2_valid_ff, s2_valid_in;
   pix_type           s2_pix_ff, s2_pix_in;
   pix_type           calc_pix;
   logic              s2_free, s1_adv, req_ready, accept;

   csc_datapath #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .mode    (mode_ff),
      .in_pix  (s1_pix_ff),
      .out_pix (calc_pix)
   );

   always_comb begin
      s2_free   = !s2_valid_ff || rsp_bus.ready;
      s1_adv    = s1_valid_ff && s2_free;
      req_ready = !s1_valid_ff || s2_free;
      accept    = req_bus.valid && req_ready;

      mode_in = csr_wr_en ? csr_wr_data : mode_ff;

      // hold the request until the result stage has room
      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_pix_in   = s1_pix_ff;
      if (accept) begin
         s1_pix_in.a = req_bus.chan_a;
         s1_pix_in.b = req_bus.chan_b;
         s1_pix_in.c = req_bus.chan_c;
      end

      s2_valid_in = s1_adv ? 1'b1 : (rsp_bus.ready ? 1'b0 : s2_valid_ff);
      s2_pix_in   = s1_adv ? calc_pix : s2_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RGB_TO_YCC;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff <= s1_pix_in;
      s2_pix_ff <= s2_pix_in;
   end

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = s2_valid_ff;
   assign rsp_bus.out_a = s2_pix_ff.a;
   assign rsp_bus.out_b = s2_pix_ff.b;
   assign rsp_bus.out_c = s2_pix_ff.c;

`ifndef SYNTHESIS
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_bus.ready)
      else $error("input stage empty but request not ready");

   a_adv_fills: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> s2_valid_ff)
      else $error("advanced request lost before result stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && !rsp_bus.ready |=> s1_valid_ff && $stable(s1_pix_ff))
      else $error("pending request dropped during output stall");

   a_grey_copy: assert property (@(posedge clock) disable iff (reset)
      s1_adv && mode_ff == MODE_YCC_TO_GREY |=> s2_pix_ff.a == $past(s1_pix_ff.a))
      else $error("luma pass-through mismatch");

   a_grey_equal: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && (mode_ff == MODE_RGB_TO_GREY || mode_ff == MODE_YCC_TO_GREY)
      |-> s2_pix_ff.a == s2_pix_ff.b && s2_pix_ff.b == s2_pix_ff.c)
      else $error("grey result channels differ");
`endif

endmodule

[dv/color_space_pixel_converter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Colour space pixel converter testbench
// Drives pixels through all four conversion modes under random source idling
// and sink stalling, predicts each converted pixel in fixed point and checks
// the responses in order.
// ----------------------------------------------------------------------------
module color_space_pixel_converter_tb;
   import csc_pkg::*;

   localparam int FRAC        = COEF_FRAC_BITS_DEF;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 4;
   localparam int LONG_HOLD   = 300;
   localparam int MAX_REPORTS = 10;

   // coefficient rounded to nearest in Q.FRAC, ties up
   function automatic longint q_coef(input longint num, input longint den);
      return ((num << FRAC) + den / 2) / den;
   endfunction

   localparam longint K_YR   = q_coef(299, 1000);
   localparam longint K_YG   = q_coef(587, 1000);
   localparam longint K_YB   = q_coef(114, 1000);
   localparam longint K_UR   = q_coef(168736, 1000000);
   localparam longint K_UG   = q_coef(331264, 1000000);
   localparam longint K_HALF = q_coef(1, 2);
   localparam longint K_VG   = q_coef(418688, 1000000);
   localparam longint K_VB   = q_coef(81312, 1000000);
   localparam longint K_RV   = q_coef(1401999, 1000000);
   localparam longint K_GU   = q_coef(344136, 1000000);
   localparam longint K_GV   = q_coef(714136, 1000000);
   localparam longint K_BU   = q_coef(1772, 1000);
   localparam longint OFS_Q  = longint'(128) << FRAC;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [MODE_W-1:0] csr_wr_data = '0;

   csc_req_if req_if ();
   csc_rsp_if rsp_if ();

   color_space_pixel_converter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   logic [MODE_W-1:0] active_mode = MODE_RGB_TO_YCC;
   pix_type           converted_q[$];
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                rsp_hold_left = 0;
   int                error_count = 0;
   int                idle_cycles = 0;

   function automatic logic [CHAN_W-1:0] floor_clamp(input longint sum);
      longint v;
      if (sum < 0) return '0;
      v = sum >>> FRAC;
      return (v > 255) ? 8'd255 : v[CHAN_W-1:0];
   endfunction

   function automatic pix_type convert_pixel(input logic [MODE_W-1:0] mode, input pix_type px);
      longint  a, b, c, u, v, y;
      pix_type res;
      a = px.a;
      b = px.b;
      c = px.c;
      case (mode)
         MODE_RGB_TO_YCC: begin
            res.a = floor_clamp(K_YR * a + K_YG * b + K_YB * c);
            res.b = floor_clamp(-K_UR * a - K_UG * b + K_HALF * c + OFS_Q);
            res.c = floor_clamp(K_HALF * a - K_VG * b - K_VB * c + OFS_Q);
         end
         MODE_YCC_TO_RGB: begin
            u = b - 128;
            v = c - 128;
            y = a << FRAC;
            res.a = floor_clamp(y + K_RV * v);
            res.b = floor_clamp(y - K_GU * u - K_GV * v);
            res.c = floor_clamp(y + K_BU * u);
         end
         MODE_RGB_TO_GREY: begin
            res.a = floor_clamp(K_YR * a + K_YG * b + K_YB * c);
            res.b = res.a;
            res.c = res.a;
         end
         default: begin
            res.a = px.a;
            res.b = px.a;
            res.c = px.a;
         end
      endcase
      return res;
   endfunction

   // request side predicts first, so an expectation is always queued ahead
   // of its response
   always @(posedge clock) begin
      pix_type got, want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            converted_q.push_back(convert_pixel(active_mode,
               '{a: req_if.chan_a, b: req_if.chan_b, c: req_if.chan_c}));
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{a: rsp_if.out_a, b: rsp_if.out_b, c: rsp_if.out_c};
            if (converted_q.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("response with nothing expected: %0d %0d %0d",
                           got.a, got.b, got.c);
            end else begin
               want = converted_q.pop_front();
               if (got.a !== want.a || got.b !== want.b || got.c !== want.c) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("mode %0d: expected a/b/c %0d %0d %0d, got %0d %0d %0d",
                              active_mode, want.a, want.b, want.c, got.a, got.b, got.c);
               end
            end
         end
      end
   end

   // sink: random stalls, or a long hold-off when one is armed
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_pixel(input pix_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.chan_a <= px.a;
      req_if.chan_b <= px.b;
      req_if.chan_c <= px.c;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // let the last accepted request reach the queue before watching it empty
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (converted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] mode);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      active_mode <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // bias toward the channel extremes so saturation is hit often
   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom_range(255);
      endcase
   endfunction

   function automatic pix_type rand_pixel();
      return '{a: rand_chan(), b: rand_chan(), c: rand_chan()};
   endfunction

   // corner pixels in every mode, the reset mode first without a write
   task automatic test_corner_pixels();
      pix_type corners[6];
      corners = '{'{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF},
                  '{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'hFF},
                  '{8'h00, 8'h00, 8'hFF}, '{8'hFF, 8'hFF, 8'h00}};
      for (int m = 0; m < 4; m++) begin
         if (m != 0) write_mode(MODE_W'(m));
         foreach (corners[i]) send_pixel(corners[i]);
      end
      wait_drained();
   endtask

   task automatic test_random_phases();
      int pacing[4][2];
      pacing = '{'{0, 0}, '{78, 0}, '{0, 78}, '{8, 8}};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = pacing[p][0];
         rsp_stall_pct = pacing[p][1];
         for (int m = 3; m >= 0; m--) begin
            write_mode(MODE_W'(m));
            repeat (30) send_pixel(rand_pixel());
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_drained();
   endtask

   // hold the sink off long enough for the block to fill and stall requests
   task automatic test_backpressure();
      write_mode(MODE_YCC_TO_RGB);
      rsp_hold_left = LONG_HOLD;
      repeat (30) send_pixel(rand_pixel());
      wait_drained();
   endtask

   // pause the source until every result is back, then resume
   task automatic test_drain_pause();
      write_mode(MODE_RGB_TO_GREY);
      rsp_stall_pct = 50;
      repeat (12) send_pixel(rand_pixel());
      wait_drained();
      repeat (12) send_pixel(rand_pixel());
      rsp_stall_pct = 0;
      wait_drained();
   endtask

   initial begin
      req_if.valid  <= 1'b0;
      req_if.chan_a <= '0;
      req_if.chan_b <= '0;
      req_if.chan_c <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_pixels();
      test_random_phases();
      test_backpressure();
      test_drain_pause();

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && converted_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
